FILE: rtl/tlfq_pkg.sv
package tlfq_pkg;

   // queue geometry
   localparam int LEVEL_DEPTH = 16;
   localparam int PTR_W       = $clog2(LEVEL_DEPTH);
   localparam int CNT_W       = $clog2(LEVEL_DEPTH + 1);
   localparam int SUM_W       = CNT_W + 1;

   // field widths
   localparam int ID_W    = 8;
   localparam int TIME_W  = 32;
   localparam int BURST_W = 16;

   // entry widths of the two levels
   localparam int UPPER_W = ID_W + TIME_W + BURST_W;
   localparam int LOWER_W = ID_W + TIME_W + 2 * BURST_W;

   // stream word widths
   localparam int REQ_TDATA_W = 64;
   localparam int RSP_TDATA_W = 128;

   typedef enum logic {
      REQ_ENQUEUE  = 1'b0,
      REQ_DISPATCH = 1'b1
   } req_kind_type;

   typedef enum logic {
      LVL_UPPER = 1'b0,
      LVL_LOWER = 1'b1
   } level_type;

   typedef enum logic [1:0] {
      RSP_FINISHED = 2'd0,
      RSP_DEMOTED  = 2'd1,
      RSP_EMPTY    = 2'd2,
      RSP_DROPPED  = 2'd3
   } rsp_status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RUN,
      ST_TURN,
      ST_WAIT,
      ST_SEND
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic enq_upper;
      logic enq_lower;
      logic drop;
      logic empty;
      logic pop_upper;
      logic pop_lower;
      logic calc_run;
      logic calc_turn;
      logic calc_wait;
   } tlfq_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic upper_empty;
      logic upper_full;
      logic lower_empty;
      logic lower_full;
   } tlfq_stat_type;

   // next head position with wrap
   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] r;
      if (p == PTR_W'(LEVEL_DEPTH - 1)) begin
         r = '0;
      end else begin
         r = p + 1'b1;
      end
      return r;
   endfunction

   // tail position from head and fill count
   function automatic logic [PTR_W-1:0] ptr_tail(input logic [PTR_W-1:0] head,
                                                 input logic [CNT_W-1:0] count);
      logic [SUM_W-1:0] s;
      logic [SUM_W-1:0] w;
      s = SUM_W'(head) + SUM_W'(count);
      if (s >= SUM_W'(LEVEL_DEPTH)) begin
         w = s - SUM_W'(LEVEL_DEPTH);
      end else begin
         w = s;
      end
      return w[PTR_W-1:0];
   endfunction

endpackage

FILE: rtl/tlfq_ram.sv
module tlfq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // single write port, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/tlfq_ctrl.sv
module tlfq_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic                   req_kind,
   input  logic                   req_level,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  tlfq_pkg::tlfq_stat_type stat,
   output tlfq_pkg::tlfq_cmd_type  cmd
);

   tlfq_pkg::state_type state_ff;
   tlfq_pkg::state_type state_in;
   logic                level_full;

   assign level_full = (req_level == tlfq_pkg::LVL_LOWER) ? stat.lower_full : stat.upper_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tlfq_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tlfq_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               if (req_kind == tlfq_pkg::REQ_ENQUEUE) begin
                  if (level_full) begin
                     state_in = tlfq_pkg::ST_SEND;
                  end
               end else if (!stat.upper_empty || !stat.lower_empty) begin
                  state_in = tlfq_pkg::ST_RUN;
               end else begin
                  state_in = tlfq_pkg::ST_SEND;
               end
            end
         end
         tlfq_pkg::ST_RUN:  state_in = tlfq_pkg::ST_TURN;
         tlfq_pkg::ST_TURN: state_in = tlfq_pkg::ST_WAIT;
         tlfq_pkg::ST_WAIT: state_in = tlfq_pkg::ST_SEND;
         tlfq_pkg::ST_SEND: begin
            if (rsp_tready) begin
               state_in = tlfq_pkg::ST_IDLE;
            end
         end
         default: state_in = tlfq_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      case (state_ff)
         tlfq_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (req_kind == tlfq_pkg::REQ_ENQUEUE) begin
                  if (level_full) begin
                     cmd.drop = 1'b1;
                  end else if (req_level == tlfq_pkg::LVL_LOWER) begin
                     cmd.enq_lower = 1'b1;
                  end else begin
                     cmd.enq_upper = 1'b1;
                  end
               end else if (!stat.upper_empty) begin
                  cmd.pop_upper = 1'b1;
               end else if (!stat.lower_empty) begin
                  cmd.pop_lower = 1'b1;
               end else begin
                  cmd.empty = 1'b1;
               end
            end
         end
         tlfq_pkg::ST_RUN:  cmd.calc_run  = 1'b1;
         tlfq_pkg::ST_TURN: cmd.calc_turn = 1'b1;
         tlfq_pkg::ST_WAIT: cmd.calc_wait = 1'b1;
         tlfq_pkg::ST_SEND: rsp_tvalid    = 1'b1;
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

FILE: rtl/tlfq_dp.sv
module tlfq_dp (
   input  logic                          clock,
   input  logic                          reset,
   input  tlfq_pkg::tlfq_cmd_type        cmd,
   output tlfq_pkg::tlfq_stat_type       stat,
   input  logic                          csr_we,
   input  logic [tlfq_pkg::BURST_W-1:0]  csr_data,
   input  logic [tlfq_pkg::ID_W-1:0]     req_job_id,
   input  logic [tlfq_pkg::TIME_W-1:0]   req_arrival,
   input  logic [tlfq_pkg::BURST_W-1:0]  req_burst,
   input  logic                          req_level,
   output logic [1:0]                    rsp_status,
   output logic [tlfq_pkg::ID_W-1:0]     rsp_served_id,
   output logic                          rsp_served_level,
   output logic [tlfq_pkg::BURST_W-1:0]  rsp_run_time,
   output logic [tlfq_pkg::TIME_W-1:0]   rsp_finish_clock,
   output logic [tlfq_pkg::TIME_W-1:0]   rsp_turnaround,
   output logic [tlfq_pkg::TIME_W-1:0]   rsp_waiting
);

   localparam int IW = tlfq_pkg::ID_W;
   localparam int TW = tlfq_pkg::TIME_W;
   localparam int BW = tlfq_pkg::BURST_W;
   localparam int PW = tlfq_pkg::PTR_W;
   localparam int CW = tlfq_pkg::CNT_W;

   // control state
   logic [TW-1:0] clock_ff, clock_in;
   logic [BW-1:0] quantum_ff, quantum_in;
   logic [PW-1:0] uhead_ff, uhead_in, lhead_ff, lhead_in;
   logic [CW-1:0] ucount_ff, ucount_in, lcount_ff, lcount_in;

   // job and result registers
   logic                 src_lower_ff;
   logic [IW-1:0]        id_ff;
   logic                 level_ff;
   logic [TW-1:0]        arr_ff;
   logic [BW-1:0]        orig_ff;
   logic [BW-1:0]        run_ff;
   logic [1:0]           status_ff;
   logic [TW-1:0]        turn_ff;
   logic [TW-1:0]        wait_ff;

   // memory ports
   logic                        u_we, l_we;
   logic [PW-1:0]               u_waddr, l_waddr;
   logic [tlfq_pkg::UPPER_W-1:0] u_wdata, u_rdata;
   logic [tlfq_pkg::LOWER_W-1:0] l_wdata, l_rdata;

   // head entry fields
   logic [IW-1:0] u_id, l_id, job_id;
   logic [TW-1:0] u_arr, l_arr, job_arr;
   logic [BW-1:0] u_burst, l_rem, l_orig, job_orig;
   logic          fits, demote, push_demote;
   logic [BW-1:0] run_sel;

   assign stat.upper_empty = (ucount_ff == '0);
   assign stat.upper_full  = (ucount_ff == CW'(tlfq_pkg::LEVEL_DEPTH));
   assign stat.lower_empty = (lcount_ff == '0);
   assign stat.lower_full  = (lcount_ff == CW'(tlfq_pkg::LEVEL_DEPTH));

   assign u_id    = u_rdata[IW-1:0];
   assign u_arr   = u_rdata[IW +: TW];
   assign u_burst = u_rdata[IW+TW +: BW];
   assign l_id    = l_rdata[IW-1:0];
   assign l_arr   = l_rdata[IW +: TW];
   assign l_rem   = l_rdata[IW+TW +: BW];
   assign l_orig  = l_rdata[IW+TW+BW +: BW];

   // run time and demotion of the head job
   assign fits        = (u_burst <= quantum_ff);
   assign demote      = !src_lower_ff && !fits;
   assign run_sel     = src_lower_ff ? l_rem : (fits ? u_burst : quantum_ff);
   assign job_id      = src_lower_ff ? l_id : u_id;
   assign job_arr     = src_lower_ff ? l_arr : u_arr;
   assign job_orig    = src_lower_ff ? l_orig : u_burst;
   assign push_demote = cmd.calc_run && demote && !stat.lower_full;

   // upper level write side
   assign u_we    = cmd.enq_upper;
   assign u_waddr = tlfq_pkg::ptr_tail(uhead_ff, ucount_ff);
   assign u_wdata = {req_burst, req_arrival, req_job_id};

   // lower level write side: new job or demoted remainder
   assign l_we    = cmd.enq_lower || push_demote;
   assign l_waddr = tlfq_pkg::ptr_tail(lhead_ff, lcount_ff);
   assign l_wdata = cmd.enq_lower ? {req_burst, req_burst, req_arrival, req_job_id}
                                  : {u_burst, u_burst - quantum_ff, u_arr, u_id};

   tlfq_ram #(.WIDTH(tlfq_pkg::UPPER_W), .DEPTH(tlfq_pkg::LEVEL_DEPTH)) u_upper_ram (
      .clock   (clock),
      .wr_en   (u_we),
      .wr_addr (u_waddr),
      .wr_data (u_wdata),
      .rd_addr (uhead_ff),
      .rd_data (u_rdata)
   );

   tlfq_ram #(.WIDTH(tlfq_pkg::LOWER_W), .DEPTH(tlfq_pkg::LEVEL_DEPTH)) u_lower_ram (
      .clock   (clock),
      .wr_en   (l_we),
      .wr_addr (l_waddr),
      .wr_data (l_wdata),
      .rd_addr (lhead_ff),
      .rd_data (l_rdata)
   );

   // next values of the control state
   always_comb begin
      clock_in   = clock_ff;
      quantum_in = quantum_ff;
      uhead_in   = uhead_ff;
      ucount_in  = ucount_ff;
      lhead_in   = lhead_ff;
      lcount_in  = lcount_ff;
      if (csr_we) begin
         quantum_in = csr_data;
      end
      if (cmd.enq_upper) begin
         ucount_in = ucount_ff + 1'b1;
      end
      if (cmd.pop_upper) begin
         uhead_in  = tlfq_pkg::ptr_next(uhead_ff);
         ucount_in = ucount_ff - 1'b1;
      end
      if (cmd.enq_lower || push_demote) begin
         lcount_in = lcount_ff + 1'b1;
      end
      if (cmd.pop_lower) begin
         lhead_in  = tlfq_pkg::ptr_next(lhead_ff);
         lcount_in = lcount_ff - 1'b1;
      end
      if (cmd.calc_run) begin
         clock_in = clock_ff + TW'(run_sel);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clock_ff   <= '0;
         quantum_ff <= BW'(2);
         uhead_ff   <= '0;
         ucount_ff  <= '0;
         lhead_ff   <= '0;
         lcount_ff  <= '0;
      end else begin
         clock_ff   <= clock_in;
         quantum_ff <= quantum_in;
         uhead_ff   <= uhead_in;
         ucount_ff  <= ucount_in;
         lhead_ff   <= lhead_in;
         lcount_ff  <= lcount_in;
      end
   end

   // job and result registers, one step per state
   always_ff @(posedge clock) begin
      if (cmd.pop_upper || cmd.pop_lower) begin
         src_lower_ff <= cmd.pop_lower;
      end
      if (cmd.drop) begin
         status_ff <= tlfq_pkg::RSP_DROPPED;
         id_ff     <= req_job_id;
         level_ff  <= req_level;
         run_ff    <= '0;
         turn_ff   <= '0;
         wait_ff   <= '0;
      end else if (cmd.empty) begin
         status_ff <= tlfq_pkg::RSP_EMPTY;
         id_ff     <= '0;
         level_ff  <= tlfq_pkg::LVL_UPPER;
         run_ff    <= '0;
         turn_ff   <= '0;
         wait_ff   <= '0;
      end else if (cmd.calc_run) begin
         status_ff <= demote ? tlfq_pkg::RSP_DEMOTED : tlfq_pkg::RSP_FINISHED;
         id_ff     <= job_id;
         level_ff  <= src_lower_ff;
         arr_ff    <= job_arr;
         orig_ff   <= job_orig;
         run_ff    <= run_sel;
      end else if (cmd.calc_turn) begin
         if (status_ff == tlfq_pkg::RSP_DEMOTED || clock_ff < arr_ff) begin
            turn_ff <= '0;
         end else begin
            turn_ff <= clock_ff - arr_ff;
         end
      end else if (cmd.calc_wait) begin
         if (turn_ff >= TW'(orig_ff)) begin
            wait_ff <= turn_ff - TW'(orig_ff);
         end else begin
            wait_ff <= '0;
         end
      end
   end

   assign rsp_status       = status_ff;
   assign rsp_served_id    = id_ff;
   assign rsp_served_level = level_ff;
   assign rsp_run_time     = run_ff;
   assign rsp_finish_clock = clock_ff;
   assign rsp_turnaround   = turn_ff;
   assign rsp_waiting      = wait_ff;

endmodule

FILE: rtl/two_level_feedback_queue_scheduler_core.sv
// Two-level feedback queue scheduler. Jobs are enqueued on an upper level
// (time-sliced by the quantum register, reset value 2) or a lower level (run
// to completion), each a FIFO of 16 entries held in a small RAM with a
// registered read. A dispatch serves the upper level first; an upper job that
// does not fit its quantum runs one quantum and its remainder moves to the
// tail of the lower level, or is lost if that level is full. The block
// handles one word at a time: a good enqueue is taken and gives no result; a
// dropped enqueue or a dispatch with both levels empty offers its result in
// the cycle after it is taken; a dispatch that runs a job reads the head,
// then steps RUN (run time, clock add), TURN (turnaround subtract) and WAIT
// (waiting subtract) and offers its result in SEND. The next request is taken
// in the cycle after the result word leaves. No clearing pass follows reset.
module two_level_feedback_queue_scheduler_core (
   input  logic                               clock,
   input  logic                               reset,
   // request stream
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // job_id[7:0], arrival[39:8], burst[55:40], level[56], zero fill
   input  logic [tlfq_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // req_type[0]
   input  logic                               req_tuser,
   // response stream
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // served_id[7:0], served_level[8], run_time[24:9], finish_clock[56:25],
   // turnaround[88:57], waiting[120:89], zero fill
   output logic [tlfq_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   // status[1:0]
   output logic [1:0]                         rsp_tuser,
   // quantum register write
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [tlfq_pkg::BURST_W-1:0]       csr_data
);

   tlfq_pkg::tlfq_cmd_type  cmd;
   tlfq_pkg::tlfq_stat_type stat;

   logic [tlfq_pkg::ID_W-1:0]    req_job_id;
   logic [tlfq_pkg::TIME_W-1:0]  req_arrival;
   logic [tlfq_pkg::BURST_W-1:0] req_burst;
   logic                         req_level;

   logic [1:0]                   rsp_status;
   logic [tlfq_pkg::ID_W-1:0]    rsp_served_id;
   logic                         rsp_served_level;
   logic [tlfq_pkg::BURST_W-1:0] rsp_run_time;
   logic [tlfq_pkg::TIME_W-1:0]  rsp_finish_clock;
   logic [tlfq_pkg::TIME_W-1:0]  rsp_turnaround;
   logic [tlfq_pkg::TIME_W-1:0]  rsp_waiting;

   // request word unpacking
   assign req_job_id  = req_tdata[7:0];
   assign req_arrival = req_tdata[39:8];
   assign req_burst   = req_tdata[55:40];
   assign req_level   = req_tdata[56];

   assign csr_ready = 1'b1;

   tlfq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_kind   (req_tuser),
      .req_level  (req_level),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   tlfq_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .csr_we           (csr_valid),
      .csr_data         (csr_data),
      .req_job_id       (req_job_id),
      .req_arrival      (req_arrival),
      .req_burst        (req_burst),
      .req_level        (req_level),
      .rsp_status       (rsp_status),
      .rsp_served_id    (rsp_served_id),
      .rsp_served_level (rsp_served_level),
      .rsp_run_time     (rsp_run_time),
      .rsp_finish_clock (rsp_finish_clock),
      .rsp_turnaround   (rsp_turnaround),
      .rsp_waiting      (rsp_waiting)
   );

   // response word packing
   assign rsp_tuser = rsp_status;
   assign rsp_tdata = {7'd0, rsp_waiting, rsp_turnaround, rsp_finish_clock,
                       rsp_run_time, rsp_served_level, rsp_served_id};

endmodule

FILE: rtl/tlfq_chk.sv
module tlfq_chk (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tready,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [tlfq_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input logic [1:0]                       rsp_tuser
);

   // a stalled response word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response word changed while stalled");

   // no new request while a response is pending
   a_one_word: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("request taken while response pending");

   // drop and empty responses carry no run figures
   a_no_run: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == tlfq_pkg::RSP_DROPPED || rsp_tuser == tlfq_pkg::RSP_EMPTY)
      |-> rsp_tdata[24:9] == '0 && rsp_tdata[120:57] == '0)
      else $error("drop or empty response with run figures");

   // a demoted job comes from the upper level and reports no turnaround
   a_demote: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == tlfq_pkg::RSP_DEMOTED
      |-> !rsp_tdata[8] && rsp_tdata[120:57] == '0)
      else $error("demoted response malformed");

   // waiting never exceeds turnaround
   a_wait_le_turn: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == tlfq_pkg::RSP_FINISHED |-> rsp_tdata[120:89] <= rsp_tdata[88:57])
      else $error("waiting above turnaround");

endmodule

bind two_level_feedback_queue_scheduler_core tlfq_chk u_tlfq_chk (.*);
